// ----- rtl/core/mft_pkg.sv -----
// Package for the motor feedback tracker: shared types and constants.
`timescale 1ns / 1ps

package mft_pkg;

	// Motor status codes as reported on the result channel.
	typedef enum logic [1:0] {
		ST_OFFLINE = 2'd0,
		ST_STOP    = 2'd1,
		ST_RUN     = 2'd2
	} mft_status_t;

	// Request kinds on the input channel.
	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENC     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL   = 2'd3;
	localparam int unsigned CFG_DATA_W = 17;

	// Reset values of the configuration registers.
	localparam logic [16:0] ENC_RESET     = 17'd8192;
	localparam logic [15:0] TIMEOUT_RESET = 16'd50;
	localparam logic [14:0] STALL_RESET   = 15'd50;

	typedef struct packed {
		logic        track_position;
		logic [16:0] encoder_counts;
		logic [15:0] offline_timeout_ms;
		logic [14:0] stall_speed;
	} mft_cfg_t;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] angle_word;
		logic signed [15:0] speed_word;
		logic signed [15:0] current_word;
		logic signed [7:0]  temp_byte;
		logic [31:0]        time_ms;
	} mft_item_t;

	typedef struct packed {
		logic [31:0]        last_frame_time;
		logic signed [15:0] angle;
		logic signed [15:0] speed;
		logic signed [15:0] current;
		logic signed [7:0]  temp;
		logic [31:0]        position;
		logic signed [15:0] prev_angle;
		mft_status_t        status;
	} mft_state_t;

endpackage

// ----- rtl/core/mft_update.sv -----
// Next-state logic of the tracker for one frame or tick word.
`timescale 1ns / 1ps

module mft_update (
	input  mft_pkg::mft_cfg_t   cfg,
	input  mft_pkg::mft_item_t  item,
	input  mft_pkg::mft_state_t cur,
	output mft_pkg::mft_state_t nxt
);
	import mft_pkg::*;

	logic               frame_take;
	logic signed [16:0] step;
	logic [16:0]        step_mag;
	logic [15:0]        half_counts;
	logic signed [18:0] step_ext;
	logic signed [18:0] enc_ext;
	logic signed [18:0] step_fix;
	logic [31:0]        elapsed;
	logic [16:0]        speed_abs;
	logic signed [16:0] speed_wide;

	// Angle step since the previous sample, folded back by one revolution
	// when it is larger than half a revolution.
	assign step        = 17'(signed'({item.angle_word[15], item.angle_word}))
		- 17'(signed'({cur.prev_angle[15], cur.prev_angle}));
	assign step_mag    = step[16] ? 17'(-step) : 17'(step);
	assign half_counts = cfg.encoder_counts[16:1];
	assign step_ext    = {{2{step[16]}}, step};
	assign enc_ext     = signed'({2'b00, cfg.encoder_counts});
	always_comb begin
		if (step_mag > {1'b0, half_counts}) begin
			step_fix = step[16] ? (step_ext + enc_ext) : (step_ext - enc_ext);
		end else begin
			step_fix = step_ext;
		end
	end

	// Tick side: elapsed time since the last frame and absolute speed.
	assign elapsed    = item.time_ms - cur.last_frame_time;
	assign speed_wide = {cur.speed[15], cur.speed};
	assign speed_abs  = speed_wide[16] ? 17'(-speed_wide) : 17'(speed_wide);

	assign frame_take = (item.time_ms >= cur.last_frame_time);

	// Combine into the state after this word.
	always_comb begin
		nxt = cur;
		if (item.req_type == REQ_FRAME) begin
			if (frame_take) begin
				nxt.angle           = item.angle_word;
				nxt.speed           = item.speed_word;
				nxt.current         = item.current_word;
				nxt.temp            = item.temp_byte;
				nxt.last_frame_time = item.time_ms;
				if (cur.status == ST_OFFLINE || !cfg.track_position) begin
					nxt.position = '0;
				end else if (cur.position == '0 && cur.prev_angle == '0) begin
					nxt.prev_angle = item.angle_word;
					nxt.position   = '0;
				end else begin
					nxt.prev_angle = item.angle_word;
					nxt.position   = cur.position + {{13{step_fix[18]}}, step_fix};
				end
			end
		end else begin
			if (elapsed > {16'd0, cfg.offline_timeout_ms}) begin
				nxt.status = ST_OFFLINE;
			end else if (speed_abs < {2'b00, cfg.stall_speed}) begin
				nxt.status = ST_STOP;
			end else begin
				nxt.status = ST_RUN;
			end
		end
	end

endmodule

// ----- rtl/core/motor_feedback_tracker.sv -----
// Top level of the motor feedback tracker.
//
// Input words arrive on in_valid/in_stall: req_type selects a feedback frame
// (angle, speed, current, temperature and timestamp) or a heartbeat tick
// (current time only). Each accepted word produces exactly one result word on
// out_valid/out_stall carrying the motor status, the latest accepted frame
// fields and the multi-turn position.
// A word is captured in an input register, then combinational logic updates the
// tracker state, which also serves as the result register. Throughput is one
// word per cycle unless the receiver stalls; the result then holds, the input
// register still takes one more word, and in_stall rises only once that
// register is also full. Configuration is written through
// cfg_wr_en/cfg_index/cfg_data while no word is in flight; the user must
// ensure this, it is not enforced. Reset clears all state, sets the status to
// offline and loads the defaults (tracking on, 8192 counts, 50 ms, speed 50).
`timescale 1ns / 1ps

module motor_feedback_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mft_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic signed [15:0]            angle_word,
	input  logic signed [15:0]            speed_word,
	input  logic signed [15:0]            current_word,
	input  logic signed [7:0]             temp_byte,
	input  logic [31:0]                   time_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    motor_status,
	output logic signed [15:0]            angle_out,
	output logic signed [15:0]            speed_out,
	output logic signed [15:0]            current_out,
	output logic signed [7:0]             temp_out,
	output logic signed [31:0]            position_out
);
	import mft_pkg::*;

	mft_cfg_t   cfg_q;
	mft_item_t  item_s1;
	logic       valid_s1;
	mft_state_t state_q;
	mft_state_t state_nxt;
	logic       out_valid_q;
	logic       adv_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_position     <= 1'b1;
			cfg_q.encoder_counts     <= ENC_RESET;
			cfg_q.offline_timeout_ms <= TIMEOUT_RESET;
			cfg_q.stall_speed        <= STALL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TRACK:   cfg_q.track_position     <= cfg_data[0];
				CFG_ENC:     cfg_q.encoder_counts     <= cfg_data[16:0];
				CFG_TIMEOUT: cfg_q.offline_timeout_ms <= cfg_data[15:0];
				CFG_STALL:   cfg_q.stall_speed        <= cfg_data[14:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	// The input stage moves on whenever the result register is free or drained.
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.req_type     <= req_type;
			item_s1.angle_word   <= angle_word;
			item_s1.speed_word   <= speed_word;
			item_s1.current_word <= current_word;
			item_s1.temp_byte    <= temp_byte;
			item_s1.time_ms      <= time_ms;
		end
	end

	mft_update u_update (
		.cfg (cfg_q),
		.item(item_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	// Tracker state, which doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_frame_time <= '0;
			state_q.angle           <= '0;
			state_q.speed           <= '0;
			state_q.current         <= '0;
			state_q.temp            <= '0;
			state_q.position        <= '0;
			state_q.prev_angle      <= '0;
			state_q.status          <= ST_OFFLINE;
			out_valid_q             <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word.
	assign out_valid    = out_valid_q;
	assign motor_status = state_q.status;
	assign angle_out    = state_q.angle;
	assign speed_out    = state_q.speed;
	assign current_out  = state_q.current;
	assign temp_out     = state_q.temp;
	assign position_out = signed'(state_q.position);

endmodule
